// File: hdl/tpsf_pkg.sv
// ----------------------------------------------------------------------------
// tpsf_pkg
// widths, pipeline timing and shared saturation for the two point fit
// ----------------------------------------------------------------------------
package tpsf_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;            // coordinate difference
    localparam int PW = 2 * DW;            // difference product
    localparam int SW = PW + 1;            // sum of two products
    localparam int QW = CW + 1;            // quotient bits
    localparam int RW = SW + FRAC_BITS + QW + 2; // divider remainder
    localparam int XW = 2 * CW + 2;        // shift numerator

    localparam int DIV_LAT = QW + 3;
    localparam int LATENCY = DIV_LAT + 6;

    typedef struct packed {
        logic signed [CW-1:0] value;
        logic                 flag;
    } t_sat;

    typedef struct packed {
        logic                 valid;
        logic                 degen;
        logic signed [CW-1:0] s1x;
        logic signed [CW-1:0] s1y;
        logic signed [CW-1:0] d1x;
        logic signed [CW-1:0] d1y;
    } t_side;

    function automatic t_sat sat_mag(input logic [XW-1:0] mag, input logic neg);
        logic [XW-1:0] lim;
        t_sat          res;
        lim = XW'(1) << (CW - 1);
        if (neg) begin
            if (mag > lim) begin
                res.value = CW'(lim);
                res.flag  = 1'b1;
            end else begin
                res.value = -CW'(mag);
                res.flag  = 1'b0;
            end
        end else begin
            if (mag > lim - XW'(1)) begin
                res.value = CW'(lim - XW'(1));
                res.flag  = 1'b1;
            end else begin
                res.value = CW'(mag);
                res.flag  = 1'b0;
            end
        end
        return res;
    endfunction

    // side data of the next stage, valid dropped while in reset
    function automatic t_side gate_side(input t_side s, input logic run);
        t_side res;
        res       = s;
        res.valid = s.valid & run;
        return res;
    endfunction

endpackage

// File: hdl/tpsf_div.sv
// ----------------------------------------------------------------------------
// tpsf_div
// pipelined rounding divider, one quotient bit per stage, saturating result
// ----------------------------------------------------------------------------
module tpsf_div (
    input  logic                                 i_clk,
    input  logic signed [tpsf_pkg::SW-1:0]       i_num,
    input  logic        [tpsf_pkg::SW-1:0]       i_den,
    output logic signed [tpsf_pkg::CW-1:0]       o_q,
    output logic                                 o_sat
);
    localparam int RW = tpsf_pkg::RW;
    localparam int QW = tpsf_pkg::QW;

    logic signed [RW-1:0] num_ext;
    logic        [RW-1:0] mag;
    logic                 r_p_neg;
    logic        [RW-1:0] r_p_n2p;
    logic        [RW-1:0] r_p_d2;

    logic        [RW-1:0] r_rem [0:QW];
    logic        [RW-1:0] r_d2  [0:QW];
    logic        [QW-1:0] r_quo [0:QW];
    logic                 r_neg [0:QW];
    logic                 r_ovf [0:QW];

    tpsf_pkg::t_sat       sat_res;

    assign num_ext = RW'(i_num);
    assign mag     = i_num[tpsf_pkg::SW-1] ? RW'(-num_ext) : RW'(num_ext);

    always_ff @(posedge i_clk) begin
        r_p_neg <= i_num[tpsf_pkg::SW-1];
        r_p_n2p <= (mag << (tpsf_pkg::FRAC_BITS + 1)) + RW'(i_den);
        r_p_d2  <= RW'(i_den) << 1;
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= r_p_n2p;
        r_d2[0]  <= r_p_d2;
        r_quo[0] <= '0;
        r_neg[0] <= r_p_neg;
        r_ovf[0] <= r_p_n2p >= (r_p_d2 << QW);
    end

    for (genvar j = 1; j <= QW; j++) begin : g_stage
        logic [RW-1:0] dsh;
        assign dsh = r_d2[j-1] << (QW - j);
        always_ff @(posedge i_clk) begin
            r_d2[j]  <= r_d2[j-1];
            r_neg[j] <= r_neg[j-1];
            r_ovf[j] <= r_ovf[j-1];
            if (r_rem[j-1] >= dsh) begin
                r_rem[j] <= r_rem[j-1] - dsh;
                r_quo[j] <= r_quo[j-1] | (QW'(1) << (QW - j));
            end else begin
                r_rem[j] <= r_rem[j-1];
                r_quo[j] <= r_quo[j-1];
            end
        end
    end

    assign sat_res = tpsf_pkg::sat_mag(tpsf_pkg::XW'(r_quo[QW]), r_neg[QW]);

    always_ff @(posedge i_clk) begin
        if (r_ovf[QW]) begin
            o_q   <= r_neg[QW] ? {1'b1, {(tpsf_pkg::CW-1){1'b0}}}
                               : {1'b0, {(tpsf_pkg::CW-1){1'b1}}};
            o_sat <= 1'b1;
        end else begin
            o_q   <= sat_res.value;
            o_sat <= sat_res.flag;
        end
    end

endmodule

// File: hdl/two_point_similarity_fit_unit.sv
// ----------------------------------------------------------------------------
// two_point_similarity_fit_unit
// similarity transform fit from two source and two target points, Q16.16
// ----------------------------------------------------------------------------
// usage:
//   drive the eight point coordinates and raise start; a word is taken at
//   every clock edge with start high and busy low. busy is always low, so a
//   new word may enter in every cycle.
//   results come out on o_scale_cos, o_scale_sin, o_shift_x, o_shift_y,
//   o_degenerate and o_saturated, marked by o_valid for exactly one cycle,
//   in the order the words went in.
//   throughput is one word per cycle; the two dividers are pipelined,
//   one quotient bit per stage (coordinate width plus one stages).
//   synchronous reset drops every word in flight and clears o_valid.
//   the receiver cannot stall; results must be taken when o_valid is high.
// ----------------------------------------------------------------------------
module two_point_similarity_fit_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_src1_x,
    input  logic [31:0] i_src1_y,
    input  logic [31:0] i_src2_x,
    input  logic [31:0] i_src2_y,
    input  logic [31:0] i_dst1_x,
    input  logic [31:0] i_dst1_y,
    input  logic [31:0] i_dst2_x,
    input  logic [31:0] i_dst2_y,
    output logic        o_valid,
    output logic [31:0] o_scale_cos,
    output logic [31:0] o_scale_sin,
    output logic [31:0] o_shift_x,
    output logic [31:0] o_shift_y,
    output logic        o_degenerate,
    output logic        o_saturated
);
    localparam int CW = tpsf_pkg::CW;
    localparam int DW = tpsf_pkg::DW;
    localparam int PW = tpsf_pkg::PW;
    localparam int SW = tpsf_pkg::SW;
    localparam int XW = tpsf_pkg::XW;
    localparam int FB = tpsf_pkg::FRAC_BITS;
    localparam int DL = tpsf_pkg::DIV_LAT;

    // stage 1: differences
    logic signed [CW-1:0] s1x, s1y, s2x, s2y, d1x, d1y, d2x, d2y;
    logic signed [DW-1:0] r1_sx, r1_sy, r1_tx, r1_ty;
    tpsf_pkg::t_side      r1_side;

    // stage 2: products
    logic signed [PW-1:0] r2_pxx, r2_pyy, r2_pxt, r2_pyt, r2_pxty, r2_pytx;
    tpsf_pkg::t_side      r2_side;

    // stage 3: sums
    logic signed [SW-1:0] r3_n2, r3_dot, r3_crs;
    tpsf_pkg::t_side      r3_side;
    logic        [SW-1:0] den;

    tpsf_pkg::t_side      r_dly [0:DL-1];

    logic signed [CW-1:0] div_a, div_b;
    logic                 sat_a, sat_b;

    // stage 4: shift products
    logic signed [2*CW-1:0] r4_as1x, r4_bs1y, r4_bs1x, r4_as1y;
    logic signed [CW-1:0]   r4_a, r4_b, r4_d1x, r4_d1y;
    logic                   r4_sat, r4_valid, r4_degen;

    // stage 5: shift numerators
    logic signed [XW-1:0]   r5_nx, r5_ny;
    logic signed [CW-1:0]   r5_a, r5_b;
    logic                   r5_sat, r5_valid, r5_degen;

    logic        [XW-1:0]   mag_x, mag_y, q_x, q_y;
    tpsf_pkg::t_sat         sat_x, sat_y;

    assign busy = 1'b0;

    assign s1x = $signed(i_src1_x[CW-1:0]);
    assign s1y = $signed(i_src1_y[CW-1:0]);
    assign s2x = $signed(i_src2_x[CW-1:0]);
    assign s2y = $signed(i_src2_y[CW-1:0]);
    assign d1x = $signed(i_dst1_x[CW-1:0]);
    assign d1y = $signed(i_dst1_y[CW-1:0]);
    assign d2x = $signed(i_dst2_x[CW-1:0]);
    assign d2y = $signed(i_dst2_y[CW-1:0]);

    always_ff @(posedge i_clk) begin
        r1_sx       <= DW'(s2x) - DW'(s1x);
        r1_sy       <= DW'(s2y) - DW'(s1y);
        r1_tx       <= DW'(d2x) - DW'(d1x);
        r1_ty       <= DW'(d2y) - DW'(d1y);
        r1_side.s1x <= s1x;
        r1_side.s1y <= s1y;
        r1_side.d1x <= d1x;
        r1_side.d1y <= d1y;
        r1_side.degen <= 1'b0;
        if (!i_rst_n) begin
            r1_side.valid <= 1'b0;
        end else begin
            r1_side.valid <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_pxx  <= PW'(r1_sx) * PW'(r1_sx);
        r2_pyy  <= PW'(r1_sy) * PW'(r1_sy);
        r2_pxt  <= PW'(r1_sx) * PW'(r1_tx);
        r2_pyt  <= PW'(r1_sy) * PW'(r1_ty);
        r2_pxty <= PW'(r1_sx) * PW'(r1_ty);
        r2_pytx <= PW'(r1_sy) * PW'(r1_tx);
        r2_side <= {r1_side.valid & i_rst_n, (r1_sx == '0) && (r1_sy == '0),
                    r1_side.s1x, r1_side.s1y, r1_side.d1x, r1_side.d1y};
    end

    always_ff @(posedge i_clk) begin
        r3_n2   <= SW'(r2_pxx) + SW'(r2_pyy);
        r3_dot  <= SW'(r2_pxt) + SW'(r2_pyt);
        r3_crs  <= SW'(r2_pxty) - SW'(r2_pytx);
        r3_side <= tpsf_pkg::gate_side(r2_side, i_rst_n);
    end

    assign den = r3_side.degen ? SW'(1) : SW'(r3_n2);

    tpsf_div u_div_a (
        .i_clk (i_clk),
        .i_num (r3_dot),
        .i_den (den),
        .o_q   (div_a),
        .o_sat (sat_a)
    );

    tpsf_div u_div_b (
        .i_clk (i_clk),
        .i_num (r3_crs),
        .i_den (den),
        .o_q   (div_b),
        .o_sat (sat_b)
    );

    always_ff @(posedge i_clk) begin
        r_dly[0] <= tpsf_pkg::gate_side(r3_side, i_rst_n);
    end

    for (genvar k = 1; k < DL; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            r_dly[k] <= tpsf_pkg::gate_side(r_dly[k-1], i_rst_n);
        end
    end

    always_ff @(posedge i_clk) begin
        r4_as1x  <= (2*CW)'(div_a) * (2*CW)'(r_dly[DL-1].s1x);
        r4_bs1y  <= (2*CW)'(div_b) * (2*CW)'(r_dly[DL-1].s1y);
        r4_bs1x  <= (2*CW)'(div_b) * (2*CW)'(r_dly[DL-1].s1x);
        r4_as1y  <= (2*CW)'(div_a) * (2*CW)'(r_dly[DL-1].s1y);
        r4_a     <= div_a;
        r4_b     <= div_b;
        r4_d1x   <= r_dly[DL-1].d1x;
        r4_d1y   <= r_dly[DL-1].d1y;
        r4_sat   <= sat_a | sat_b;
        r4_degen <= r_dly[DL-1].degen;
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r_dly[DL-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_nx    <= (XW'(r4_d1x) <<< FB) - XW'(r4_as1x) + XW'(r4_bs1y);
        r5_ny    <= (XW'(r4_d1y) <<< FB) - XW'(r4_bs1x) - XW'(r4_as1y);
        r5_a     <= r4_a;
        r5_b     <= r4_b;
        r5_sat   <= r4_sat;
        r5_degen <= r4_degen;
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
    end

    assign mag_x = r5_nx[XW-1] ? XW'(-r5_nx) : XW'(r5_nx);
    assign mag_y = r5_ny[XW-1] ? XW'(-r5_ny) : XW'(r5_ny);
    assign q_x   = (mag_x + (XW'(1) << (FB - 1))) >> FB;
    assign q_y   = (mag_y + (XW'(1) << (FB - 1))) >> FB;
    assign sat_x = tpsf_pkg::sat_mag(q_x, r5_nx[XW-1]);
    assign sat_y = tpsf_pkg::sat_mag(q_y, r5_ny[XW-1]);

    always_ff @(posedge i_clk) begin
        if (r5_degen) begin
            o_scale_cos  <= '0;
            o_scale_sin  <= '0;
            o_shift_x    <= '0;
            o_shift_y    <= '0;
            o_degenerate <= 1'b1;
            o_saturated  <= 1'b0;
        end else begin
            o_scale_cos  <= 32'(r5_a);
            o_scale_sin  <= 32'(r5_b);
            o_shift_x    <= 32'(sat_x.value);
            o_shift_y    <= 32'(sat_y.value);
            o_degenerate <= 1'b0;
            o_saturated  <= r5_sat | sat_x.flag | sat_y.flag;
        end
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r5_valid;
        end
    end

endmodule

// File: hdl/tpsf_checker.sv
// ----------------------------------------------------------------------------
// tpsf_checker
// port level checks of the two point fit unit, bound to the top level
// ----------------------------------------------------------------------------
module tpsf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [31:0] o_scale_cos,
    input logic [31:0] o_scale_sin,
    input logic [31:0] o_shift_x,
    input logic [31:0] o_shift_y,
    input logic        o_degenerate,
    input logic        o_saturated
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_word_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, tpsf_pkg::LATENCY))
        else $error("result without accepted word");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_scale_cos == '0 && o_scale_sin == '0 &&
        o_shift_x == '0 && o_shift_y == '0 && !o_saturated))
        else $error("degenerate result not zero");

    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

bind two_point_similarity_fit_unit tpsf_checker u_tpsf_checker (.*);
